### src/rpc_frame_deframer_defines.svh
// Assertion macros shared by the frame deframer RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef RPC_FRAME_DEFRAMER_DEFINES_SVH
`define RPC_FRAME_DEFRAMER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define RFD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RFD_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define RFD_ASSERT(label, clk, rst, prop, msg)
`define RFD_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

### src/rfd_pkg.sv
// Shared types and constants for the length-prefixed frame deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package rfd_pkg;

   localparam int DEF_MAX_FRAME_BYTES = 65535;
   localparam int DEF_QUEUE_DEPTH     = 2;

   localparam int HEADER_WORD_BYTES = 6 * 4;
   localparam int DELIM_BYTES       = 2;
   localparam int MIN_FRAME_BYTES   = HEADER_WORD_BYTES + DELIM_BYTES;
   localparam int WORD_BYTES        = 4;
   localparam int END_BYTES         = 1;
   // fixed bytes that must still fit after each variable section
   localparam int ID_TAIL_BYTES     = 17;
   localparam int NAME_TAIL_BYTES   = 13;
   localparam int INFO_TAIL_BYTES   = 5;
   localparam int TRAILER_BYTES     = WORD_BYTES + END_BYTES;

   localparam int CSR_DATA_W  = 8;
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_DELIM = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_DELIM   = 1'd1;
   localparam logic [CSR_DATA_W-1:0] START_DELIM_RESET = 8'd2;
   localparam logic [CSR_DATA_W-1:0] END_DELIM_RESET   = 8'd3;

   typedef enum logic [3:0] {
      SEC_TOTAL_LEN = 4'd0,
      SEC_ID_LEN    = 4'd1,
      SEC_ID        = 4'd2,
      SEC_NAME_LEN  = 4'd3,
      SEC_NAME      = 4'd4,
      SEC_ERR_CODE  = 4'd5,
      SEC_INFO_LEN  = 4'd6,
      SEC_INFO      = 4'd7,
      SEC_PAYLOAD   = 4'd8,
      SEC_CHECKSUM  = 4'd9,
      SEC_END       = 4'd10,
      SEC_HUNT      = 4'd15
   } section_type;

   typedef enum logic [2:0] {
      ST_BUSY      = 3'd0,
      ST_OK        = 3'd1,
      ST_BAD_END   = 3'd2,
      ST_OVERRUN   = 3'd3,
      ST_BAD_TOTAL = 3'd4
   } status_type;

   typedef struct packed {
      logic [3:0]  section;
      logic [7:0]  data_byte;
      logic [31:0] word_value;
      logic        word_done;
      logic        frame_last;
      logic [2:0]  frame_status;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

`default_nettype wire

### src/rpc_frame_deframer.sv
// Flow: an accepted byte's result item is written into the queue, then moves into the
// output register when that register is empty or its item is being taken.
// Throughput: one byte per cycle unless the queue is full; each byte needs one counter
// update, one 34-bit length compare in the parser; queue plus output register keep it fed.
// Reset (synchronous, active high): parser hunting, queue empty, no result valid,
// start delimiter 2, end delimiter 3. Depends on rfd_pkg, rfd_front, rfd_queue, rfd_back.
`default_nettype none

module rpc_frame_deframer #(
   parameter int MAX_FRAME_BYTES = rfd_pkg::DEF_MAX_FRAME_BYTES,
   parameter int QUEUE_DEPTH     = rfd_pkg::DEF_QUEUE_DEPTH
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_ready,
   input  wire  [7:0]                            req_in_byte,
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output logic [3:0]                            rsp_section,
   output logic [7:0]                            rsp_data_byte,
   output logic [31:0]                           rsp_word_value,
   output logic                                  rsp_word_done,
   output logic                                  rsp_frame_last,
   output logic [2:0]                            rsp_frame_status,
   input  wire                                   csr_write_en,
   input  wire  [rfd_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire  [rfd_pkg::CSR_DATA_W-1:0]        csr_write_data
);
   import rfd_pkg::*;

   logic [CSR_DATA_W-1:0] start_delim_ff, start_delim_in;
   logic [CSR_DATA_W-1:0] end_delim_ff,   end_delim_in;

   logic      push;
   item_type  push_item;
   logic      pop;
   item_type  head_item;
   qstat_type q_stat;

   always_comb begin
      start_delim_in = start_delim_ff;
      end_delim_in   = end_delim_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_START_DELIM: start_delim_in = csr_write_data;
            CSR_END_DELIM:   end_delim_in   = csr_write_data;
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_delim_ff <= START_DELIM_RESET;
         end_delim_ff   <= END_DELIM_RESET;
      end else begin
         start_delim_ff <= start_delim_in;
         end_delim_ff   <= end_delim_in;
      end
   end

   rfd_front #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .start_delim (start_delim_ff),
      .end_delim   (end_delim_ff),
      .q_stat      (q_stat),
      .push        (push),
      .push_item   (push_item)
   );

   rfd_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .stat      (q_stat)
   );

   rfd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_item        (head_item),
      .q_stat           (q_stat),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_section      (rsp_section),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_word_value   (rsp_word_value),
      .rsp_word_done    (rsp_word_done),
      .rsp_frame_last   (rsp_frame_last),
      .rsp_frame_status (rsp_frame_status)
   );

endmodule

`default_nettype wire

### src/rfd_queue.sv
// Small flop-based FIFO of result items between parser and output stage.
// Depends on rfd_pkg and rpc_frame_deframer_defines.svh.
`default_nettype none
`include "rpc_frame_deframer_defines.svh"

module rfd_queue #(
   parameter int DEPTH = rfd_pkg::DEF_QUEUE_DEPTH
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  rfd_pkg::item_type    push_item,
   input  wire                  pop,
   output rfd_pkg::item_type    head_item,
   output rfd_pkg::qstat_type   stat
);
   import rfd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   item_type         slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item  = slot_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == FULL_CNT);
   assign stat.empty = (count_ff == '0);

   `RFD_ASSERT_NEVER(a_no_push_full, clock, reset, push && stat.full && !pop, "push into full queue")
   `RFD_ASSERT_NEVER(a_no_pop_empty, clock, reset, pop && stat.empty, "pop from empty queue")

endmodule

`default_nettype wire

### src/rfd_front.sv
// Front end: hunts for the start delimiter, walks the frame sections and
// classifies each byte into a result item. Depends on rfd_pkg and the defines header.
`default_nettype none
`include "rpc_frame_deframer_defines.svh"

module rfd_front #(
   parameter int MAX_FRAME_BYTES = rfd_pkg::DEF_MAX_FRAME_BYTES
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  wire  [7:0]           req_in_byte,
   input  wire  [7:0]           start_delim,
   input  wire  [7:0]           end_delim,
   input  rfd_pkg::qstat_type   q_stat,
   output logic                 push,
   output rfd_pkg::item_type    push_item
);
   import rfd_pkg::*;

   localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam int SUM_W = 34;
   localparam logic [POS_W-1:0] WORD_LEN    = POS_W'(WORD_BYTES);
   localparam logic [POS_W-1:0] END_LEN     = POS_W'(END_BYTES);
   localparam logic [POS_W-1:0] TRAILER_LEN = POS_W'(TRAILER_BYTES);

   section_type      section_ff, section_in;
   logic [POS_W-1:0] pos_ff,     pos_in;
   logic [POS_W-1:0] total_ff,   total_in;
   logic [POS_W-1:0] remain_ff,  remain_in;
   logic [23:0]      shift_ff,   shift_in;
   logic             skip_ff,    skip_in;

   logic             accept;
   logic             hunting;
   logic [POS_W-1:0] pos_inc;
   logic [31:0]      word;
   logic             sec_done;
   logic             is_word;
   logic             total_bad;
   logic [4:0]       tail;
   logic [SUM_W-1:0] reach;
   logic             overrun;
   logic [POS_W-1:0] payload_len;
   logic             skip_end;

   assign req_ready   = !q_stat.full;
   assign accept      = req_valid && req_ready;
   assign hunting     = (section_ff == SEC_HUNT);
   assign pos_inc     = pos_ff + 1'b1;
   assign word        = {shift_ff, req_in_byte};
   assign sec_done    = (remain_ff <= POS_W'(1));
   assign total_bad   = (word < 32'(MIN_FRAME_BYTES)) || (word > 32'(MAX_FRAME_BYTES));
   assign payload_len = total_ff - pos_inc - TRAILER_LEN;
   assign skip_end    = (pos_inc >= total_ff);
   assign is_word     = (section_ff == SEC_TOTAL_LEN) || (section_ff == SEC_ID_LEN) ||
                        (section_ff == SEC_NAME_LEN)  || (section_ff == SEC_ERR_CODE) ||
                        (section_ff == SEC_INFO_LEN)  || (section_ff == SEC_CHECKSUM);

   always_comb begin
      unique case (section_ff)
         SEC_ID_LEN:   tail = 5'(ID_TAIL_BYTES);
         SEC_NAME_LEN: tail = 5'(NAME_TAIL_BYTES);
         default:      tail = 5'(INFO_TAIL_BYTES);
      endcase
   end

   // length word plus the fixed fields behind it must stay inside the frame
   assign reach   = SUM_W'(word) + SUM_W'(pos_inc) + SUM_W'(tail);
   assign overrun = reach > SUM_W'(total_ff);

   // next state
   always_comb begin
      section_in = section_ff;
      pos_in     = pos_ff;
      total_in   = total_ff;
      remain_in  = remain_ff;
      shift_in   = shift_ff;
      skip_in    = skip_ff;
      if (accept) begin
         if (hunting) begin
            if (req_in_byte == start_delim) begin
               pos_in     = POS_W'(1);
               total_in   = '0;
               skip_in    = 1'b0;
               section_in = SEC_TOTAL_LEN;
               remain_in  = WORD_LEN;
            end
         end else if (skip_ff) begin
            pos_in = pos_inc;
            if (skip_end) begin
               skip_in    = 1'b0;
               section_in = SEC_HUNT;
            end
         end else begin
            pos_in    = pos_inc;
            shift_in  = word[23:0];
            remain_in = remain_ff - 1'b1;
            if (sec_done) begin
               unique case (section_ff)
                  SEC_TOTAL_LEN: begin
                     if (total_bad) begin
                        section_in = SEC_HUNT;
                     end else begin
                        total_in   = word[POS_W-1:0];
                        section_in = SEC_ID_LEN;
                        remain_in  = WORD_LEN;
                     end
                  end
                  SEC_ID_LEN: begin
                     if (overrun) begin
                        skip_in = 1'b1;
                     end else if (word == '0) begin
                        section_in = SEC_NAME_LEN;
                        remain_in  = WORD_LEN;
                     end else begin
                        section_in = SEC_ID;
                        remain_in  = word[POS_W-1:0];
                     end
                  end
                  SEC_ID: begin
                     section_in = SEC_NAME_LEN;
                     remain_in  = WORD_LEN;
                  end
                  SEC_NAME_LEN: begin
                     if (overrun) begin
                        skip_in = 1'b1;
                     end else if (word == '0) begin
                        section_in = SEC_ERR_CODE;
                        remain_in  = WORD_LEN;
                     end else begin
                        section_in = SEC_NAME;
                        remain_in  = word[POS_W-1:0];
                     end
                  end
                  SEC_NAME, SEC_ERR_CODE: begin
                     section_in = (section_ff == SEC_NAME) ? SEC_ERR_CODE : SEC_INFO_LEN;
                     remain_in  = WORD_LEN;
                  end
                  SEC_INFO_LEN, SEC_INFO: begin
                     if (section_ff == SEC_INFO_LEN && overrun) begin
                        skip_in = 1'b1;
                     end else if (section_ff == SEC_INFO_LEN && word != '0) begin
                        section_in = SEC_INFO;
                        remain_in  = word[POS_W-1:0];
                     end else if (payload_len == '0) begin
                        section_in = SEC_CHECKSUM;
                        remain_in  = WORD_LEN;
                     end else begin
                        section_in = SEC_PAYLOAD;
                        remain_in  = payload_len;
                     end
                  end
                  SEC_PAYLOAD: begin
                     section_in = SEC_CHECKSUM;
                     remain_in  = WORD_LEN;
                  end
                  SEC_CHECKSUM: begin
                     section_in = SEC_END;
                     remain_in  = END_LEN;
                  end
                  default: begin
                     section_in = SEC_HUNT;
                  end
               endcase
            end
         end
      end
   end

   // result item
   always_comb begin
      push                   = 1'b0;
      push_item.section      = section_ff;
      push_item.data_byte    = req_in_byte;
      push_item.word_value   = '0;
      push_item.word_done    = 1'b0;
      push_item.frame_last   = 1'b0;
      push_item.frame_status = ST_BUSY;
      if (accept && !hunting) begin
         if (skip_ff) begin
            push                   = skip_end;
            push_item.section      = SEC_END;
            push_item.frame_last   = 1'b1;
            push_item.frame_status = ST_OVERRUN;
         end else begin
            push = 1'b1;
            if (sec_done) begin
               if (is_word) begin
                  push_item.word_value = word;
                  push_item.word_done  = 1'b1;
               end
               if (section_ff == SEC_TOTAL_LEN && total_bad) begin
                  push_item.frame_last   = 1'b1;
                  push_item.frame_status = ST_BAD_TOTAL;
               end else if (section_ff == SEC_END) begin
                  push_item.frame_last   = 1'b1;
                  push_item.frame_status = (req_in_byte == end_delim) ? ST_OK : ST_BAD_END;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         section_ff <= SEC_HUNT;
         pos_ff     <= '0;
         total_ff   <= '0;
         remain_ff  <= '0;
         skip_ff    <= 1'b0;
      end else begin
         section_ff <= section_in;
         pos_ff     <= pos_in;
         total_ff   <= total_in;
         remain_ff  <= remain_in;
         skip_ff    <= skip_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
   end

   `RFD_ASSERT(a_skip_in_len, clock, reset, skip_ff |-> (section_ff == SEC_ID_LEN || section_ff == SEC_NAME_LEN || section_ff == SEC_INFO_LEN), "overrun skip outside a length section")
   `RFD_ASSERT(a_last_hunts, clock, reset, (push && push_item.frame_last) |=> (section_ff == SEC_HUNT), "frame closed but parser not hunting")
   `RFD_ASSERT(a_pos_in_frame, clock, reset, (section_ff != SEC_HUNT && section_ff != SEC_TOTAL_LEN) |-> (pos_ff <= total_ff), "frame position past total length")

endmodule

`default_nettype wire

### src/rfd_back.sv
// Back end: pops result items from the queue into the output register.
// Depends on rfd_pkg.
`default_nettype none

module rfd_back (
   input  wire                  clock,
   input  wire                  reset,
   input  rfd_pkg::item_type    head_item,
   input  rfd_pkg::qstat_type   q_stat,
   output logic                 pop,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output logic [3:0]           rsp_section,
   output logic [7:0]           rsp_data_byte,
   output logic [31:0]          rsp_word_value,
   output logic                 rsp_word_done,
   output logic                 rsp_frame_last,
   output logic [2:0]           rsp_frame_status
);
   import rfd_pkg::*;

   logic     valid_ff, valid_in;
   item_type out_ff;

   assign pop = !q_stat.empty && (!valid_ff || rsp_ready);

   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_ff <= head_item;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_section      = out_ff.section;
   assign rsp_data_byte    = out_ff.data_byte;
   assign rsp_word_value   = out_ff.word_value;
   assign rsp_word_done    = out_ff.word_done;
   assign rsp_frame_last   = out_ff.frame_last;
   assign rsp_frame_status = out_ff.frame_status;

endmodule

`default_nettype wire

### bench/rpc_frame_deframer_tb.sv
// Self-checking bench for rpc_frame_deframer: byte stream in, section-tagged items out.
// Depends on rfd_pkg and the rpc_frame_deframer RTL. A built-in frame parser
// predicts every item, which is checked field by field.
`timescale 1ns / 100ps

module rpc_frame_deframer_tb;
   import rfd_pkg::*;

   localparam int MAX_FRAME   = DEF_MAX_FRAME_BYTES;
   localparam int DRAIN_QUIET = 8;
   localparam int HOLD_CYCLES = 200;

   typedef enum {CMD_BYTE, CMD_DRAIN, CMD_CSR, CMD_IDLE, CMD_HOLD} cmd_kind_type;
   typedef enum {FLAW_NONE, FLAW_BAD_END, FLAW_OVER_ID, FLAW_OVER_NAME, FLAW_OVER_INFO}
      frame_flaw_type;

   typedef struct {
      cmd_kind_type            kind;
      logic [7:0]              value;
      logic [CSR_INDEX_W-1:0]  index;
      int                      send_pct;
      int                      recv_pct;
   } stim_cmd_type;

   logic                    clock;
   logic                    reset          = 1'b1;
   logic                    req_valid      = 1'b0;
   wire                     req_ready;
   logic [7:0]              req_in_byte    = 8'h00;
   wire                     rsp_valid;
   logic                    rsp_ready      = 1'b0;
   wire  [3:0]              rsp_section;
   wire  [7:0]              rsp_data_byte;
   wire  [31:0]             rsp_word_value;
   wire                     rsp_word_done;
   wire                     rsp_frame_last;
   wire  [2:0]              rsp_frame_status;
   logic                    csr_write_en   = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index      = CSR_START_DELIM;
   logic [CSR_DATA_W-1:0]   csr_write_data = '0;

   rpc_frame_deframer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_section      (rsp_section),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_word_value   (rsp_word_value),
      .rsp_word_done    (rsp_word_done),
      .rsp_frame_last   (rsp_frame_last),
      .rsp_frame_status (rsp_frame_status),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // stimulus side
   stim_cmd_type stim_q[$];
   int          byte_count = 0;
   int          frame_fill = 0;
   logic [7:0]  gen_start  = START_DELIM_RESET;
   logic [7:0]  gen_end    = END_DELIM_RESET;
   int          send_idle  = 0;
   int          recv_idle  = 0;
   logic        hold_start = 1'b0;
   int          hold_left  = 0;

   // parser mirror
   logic [7:0]   start_cfg = START_DELIM_RESET;
   logic [7:0]   end_cfg   = END_DELIM_RESET;
   section_type  cur_sec   = SEC_HUNT;
   logic [15:0]  frame_pos = '0;
   logic [15:0]  frame_total = '0;
   logic [31:0]  sec_left  = '0;
   logic [31:0]  word_acc  = '0;
   logic         skip_rest = 1'b0;
   item_type     section_items[$];

   logic        byte_taken   = 1'b0;
   int          quiet_cycles = 0;
   int          mismatches   = 0;

   // ---------------------------------------------------------------- parser

   function automatic logic [31:0] payload_left();
      logic [31:0] len32;
      logic [31:0] pos32;
      len32 = {16'b0, frame_total};
      pos32 = {16'b0, frame_pos};
      return len32 - pos32 - TRAILER_BYTES;
   endfunction

   // length plus the fixed fields after it must not reach past the frame end
   function automatic logic runs_past(logic [31:0] len, int tail);
      logic [33:0] reach;
      logic [33:0] limit;
      reach = {18'b0, frame_pos} + {2'b0, len} + tail;
      limit = {18'b0, frame_total};
      return reach > limit;
   endfunction

   function automatic void enter_section(section_type s, logic [31:0] n);
      if (s == SEC_ID && n == 0) begin
         s = SEC_NAME_LEN;
         n = WORD_BYTES;
      end
      if (s == SEC_NAME && n == 0) begin
         s = SEC_ERR_CODE;
         n = WORD_BYTES;
      end
      if (s == SEC_INFO && n == 0) begin
         s = SEC_PAYLOAD;
         n = payload_left();
      end
      if (s == SEC_PAYLOAD && n == 0) begin
         s = SEC_CHECKSUM;
         n = WORD_BYTES;
      end
      cur_sec  = s;
      sec_left = n;
      word_acc = '0;
   endfunction

   function automatic void deframe_byte(logic [7:0] b);
      item_type    res;
      logic [31:0] word;
      res = '0;
      if (cur_sec == SEC_HUNT) begin
         if (b == start_cfg) begin
            frame_pos   = 16'd1;
            frame_total = '0;
            skip_rest   = 1'b0;
            enter_section(SEC_TOTAL_LEN, WORD_BYTES);
         end
         return;
      end
      frame_pos = frame_pos + 16'd1;
      res.data_byte = b;
      if (skip_rest) begin
         if (frame_pos < frame_total)
            return;
         skip_rest = 1'b0;
         cur_sec = SEC_HUNT;
         res.section      = SEC_END;
         res.frame_last   = 1'b1;
         res.frame_status = ST_OVERRUN;
         section_items.insert(section_items.size(), res);
         return;
      end
      word_acc = {word_acc[23:0], b};
      word = word_acc;
      if (sec_left != 0)
         sec_left = sec_left - 1;
      res.section = cur_sec;
      if (sec_left == 0) begin
         case (cur_sec)
            SEC_TOTAL_LEN, SEC_ID_LEN, SEC_NAME_LEN, SEC_ERR_CODE, SEC_INFO_LEN,
            SEC_CHECKSUM: begin
               res.word_value = word;
               res.word_done  = 1'b1;
            end
            default: ;
         endcase
         case (cur_sec)
            SEC_TOTAL_LEN: begin
               if (word < MIN_FRAME_BYTES || word > MAX_FRAME) begin
                  res.frame_last   = 1'b1;
                  res.frame_status = ST_BAD_TOTAL;
                  cur_sec = SEC_HUNT;
               end else begin
                  frame_total = word[15:0];
                  enter_section(SEC_ID_LEN, WORD_BYTES);
               end
            end
            SEC_ID_LEN: begin
               if (runs_past(word, ID_TAIL_BYTES))
                  skip_rest = 1'b1;
               else
                  enter_section(SEC_ID, word);
            end
            SEC_ID:       enter_section(SEC_NAME_LEN, WORD_BYTES);
            SEC_NAME_LEN: begin
               if (runs_past(word, NAME_TAIL_BYTES))
                  skip_rest = 1'b1;
               else
                  enter_section(SEC_NAME, word);
            end
            SEC_NAME:     enter_section(SEC_ERR_CODE, WORD_BYTES);
            SEC_ERR_CODE: enter_section(SEC_INFO_LEN, WORD_BYTES);
            SEC_INFO_LEN: begin
               if (runs_past(word, INFO_TAIL_BYTES))
                  skip_rest = 1'b1;
               else
                  enter_section(SEC_INFO, word);
            end
            SEC_INFO:     enter_section(SEC_PAYLOAD, payload_left());
            SEC_PAYLOAD:  enter_section(SEC_CHECKSUM, WORD_BYTES);
            SEC_CHECKSUM: enter_section(SEC_END, END_BYTES);
            default: begin
               res.frame_last   = 1'b1;
               res.frame_status = (b == end_cfg) ? ST_OK : ST_BAD_END;
               cur_sec = SEC_HUNT;
            end
         endcase
      end
      section_items.insert(section_items.size(), res);
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // ------------------------------------------------------------- generator

   function automatic void push_cmd(cmd_kind_type kind, logic [7:0] value,
                                    logic [CSR_INDEX_W-1:0] index, int send_pct, int recv_pct);
      stim_cmd_type c;
      c.kind     = kind;
      c.value    = value;
      c.index    = index;
      c.send_pct = send_pct;
      c.recv_pct = recv_pct;
      stim_q.insert(stim_q.size(), c);
   endfunction

   function automatic void queue_byte(logic [7:0] b);
      push_cmd(CMD_BYTE, b, CSR_START_DELIM, 0, 0);
      byte_count++;
      frame_fill++;
   endfunction

   function automatic void queue_word(logic [31:0] w);
      queue_byte(w[31:24]);
      queue_byte(w[23:16]);
      queue_byte(w[15:8]);
      queue_byte(w[7:0]);
   endfunction

   function automatic void queue_fill(int n);
      repeat (n) queue_byte($urandom_range(255));
   endfunction

   function automatic void queue_csr(logic [CSR_INDEX_W-1:0] index, logic [7:0] value);
      push_cmd(CMD_CSR, value, index, 0, 0);
      if (index == CSR_START_DELIM)
         gen_start = value;
      else
         gen_end = value;
   endfunction

   // register writes only once the block has gone quiet
   function automatic void queue_delims(logic [7:0] s, logic [7:0] e);
      push_cmd(CMD_DRAIN, 8'h00, CSR_START_DELIM, 0, 0);
      queue_csr(CSR_START_DELIM, s);
      queue_csr(CSR_END_DELIM, e);
   endfunction

   function automatic logic [31:0] over_len(logic [31:0] bound, bit over_max);
      return over_max ? 32'hFFFF_FFFF : bound;
   endfunction

   function automatic void queue_bad_total(logic [31:0] v);
      queue_byte(gen_start);
      queue_word(v);
   endfunction

   // a length word that overruns is followed by filler up to the end position
   function automatic void queue_frame(int id_n, int name_n, int info_n, int pay_n,
                                       frame_flaw_type flaw, bit over_max);
      int total;
      total = MIN_FRAME_BYTES + id_n + name_n + info_n + pay_n;
      frame_fill = 0;
      queue_byte(gen_start);
      queue_word(total);
      if (flaw == FLAW_OVER_ID) begin
         queue_word(over_len(total - 25, over_max));
         queue_fill(total - frame_fill);
         return;
      end
      queue_word(id_n);
      queue_fill(id_n);
      if (flaw == FLAW_OVER_NAME) begin
         queue_word(over_len(total - 25 - id_n, over_max));
         queue_fill(total - frame_fill);
         return;
      end
      queue_word(name_n);
      queue_fill(name_n);
      queue_word($urandom);
      if (flaw == FLAW_OVER_INFO) begin
         queue_word(over_len(total - 25 - id_n - name_n, over_max));
         queue_fill(total - frame_fill);
         return;
      end
      queue_word(info_n);
      queue_fill(info_n);
      queue_fill(pay_n);
      queue_word($urandom);
      if (flaw == FLAW_BAD_END)
         queue_byte(gen_end ^ 8'($urandom_range(1, 255)));
      else
         queue_byte(gen_end);
   endfunction

   function automatic int rand_len(int top);
      return ($urandom_range(3) == 0) ? 0 : $urandom_range(1, top);
   endfunction

   function automatic void queue_random_unit();
      int          pick;
      logic [7:0]  b;
      logic [31:0] bad;
      pick = $urandom_range(99);
      if (pick < 10) begin
         repeat ($urandom_range(1, 6)) begin
            b = $urandom_range(255);
            if (b == gen_start)
               b = ~b;
            queue_byte(b);
         end
      end else if (pick < 16) begin
         case ($urandom_range(2))
            0:       bad = $urandom_range(MIN_FRAME_BYTES - 1);
            1:       bad = MAX_FRAME + 1 + $urandom_range(255);
            default: bad = $urandom | 32'h0001_0000;
         endcase
         queue_bad_total(bad);
      end else if (pick < 22) begin
         // start followed by garbage
         queue_byte(gen_start);
         queue_fill($urandom_range(1, 8));
      end else if (pick < 36) begin
         queue_frame(rand_len(6), rand_len(6), rand_len(6), rand_len(12),
                     frame_flaw_type'(FLAW_OVER_ID + $urandom_range(2)), $urandom_range(1));
      end else if (pick < 44) begin
         queue_frame(rand_len(6), rand_len(6), rand_len(6), rand_len(12), FLAW_BAD_END, 0);
      end else begin
         queue_frame(rand_len(6), rand_len(6), rand_len(6), rand_len(12), FLAW_NONE, 0);
      end
   endfunction

   // ---------------------------------------------------------------- clocking

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("rpc_frame_deframer_tb failed");
      $finish;
   end

   // ------------------------------------------------------------------ driver

   always @(negedge clock) begin : drive_proc
      stim_cmd_type head;
      logic         next_valid;
      logic         next_wen;
      logic         next_hold;
      next_valid = req_valid && !byte_taken;
      next_wen   = 1'b0;
      next_hold  = 1'b0;
      if (!reset && !next_valid && stim_q.size() != 0) begin
         head = stim_q[0];
         case (head.kind)
            CMD_BYTE: begin
               if ($urandom_range(99) >= send_idle) begin
                  void'(stim_q.pop_front());
                  next_valid = 1'b1;
                  req_in_byte <= head.value;
               end
            end
            CMD_DRAIN: begin
               if (section_items.size() == 0 && quiet_cycles >= DRAIN_QUIET)
                  void'(stim_q.pop_front());
            end
            CMD_CSR: begin
               void'(stim_q.pop_front());
               next_wen = 1'b1;
               csr_index      <= head.index;
               csr_write_data <= head.value;
               if (head.index == CSR_START_DELIM)
                  start_cfg <= head.value;
               else
                  end_cfg <= head.value;
            end
            CMD_IDLE: begin
               void'(stim_q.pop_front());
               send_idle = head.send_pct;
               recv_idle <= head.recv_pct;
            end
            default: begin
               void'(stim_q.pop_front());
               next_hold = 1'b1;
            end
         endcase
      end
      req_valid    <= next_valid;
      csr_write_en <= next_wen;
      hold_start   <= next_hold;
   end

   // receiver: random stalls plus one long hold-off
   always @(negedge clock) begin
      if (hold_start)
         hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // ----------------------------------------------------------------- monitor

   always @(posedge clock) begin : check_proc
      item_type want;
      byte_taken = 1'b0;
      if (!reset) begin
         quiet_cycles = quiet_cycles + 1;
         if (req_valid && req_ready) begin
            byte_taken   = 1'b1;
            quiet_cycles = 0;
            deframe_byte(req_in_byte);
         end
         if (rsp_valid && rsp_ready) begin
            quiet_cycles = 0;
            if (section_items.size() == 0) begin
               $display("%0t: unexpected item, expected none, got section %0d byte %h",
                        $time, rsp_section, rsp_data_byte);
               mismatches++;
            end else begin
               want = section_items.pop_front();
               check_field("section", want.section, rsp_section);
               check_field("data_byte", want.data_byte, rsp_data_byte);
               check_field("word_value", want.word_value, rsp_word_value);
               check_field("word_done", want.word_done, rsp_word_done);
               check_field("frame_last", want.frame_last, rsp_frame_last);
               check_field("frame_status", want.frame_status, rsp_frame_status);
            end
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   initial begin
      push_cmd(CMD_IDLE, 8'h00, CSR_START_DELIM, 6, 52);

      // directed: hunting noise, minimum frame, bad totals, empty sections,
      // exact-fit id, bad end, overruns at the boundary and at the maximum
      queue_byte(8'h00);
      queue_byte(8'hFF);
      queue_byte(END_DELIM_RESET);
      queue_frame(0, 0, 0, 0, FLAW_NONE, 0);
      queue_bad_total(MIN_FRAME_BYTES - 1);
      queue_bad_total(MAX_FRAME + 1);
      queue_bad_total(32'hFFFF_FFFF);
      queue_bad_total(32'h0000_0000);
      queue_frame(2, 3, 1, 4, FLAW_NONE, 0);
      queue_frame(5, 0, 0, 0, FLAW_NONE, 0);
      queue_frame(1, 0, 2, 0, FLAW_BAD_END, 0);
      queue_frame(0, 1, 0, 3, FLAW_NONE, 0);
      queue_frame(3, 2, 1, 1, FLAW_OVER_ID, 0);
      queue_frame(1, 1, 1, 1, FLAW_OVER_ID, 1);
      queue_frame(1, 2, 3, 1, FLAW_OVER_NAME, 0);
      queue_frame(0, 2, 1, 0, FLAW_OVER_NAME, 1);
      queue_frame(2, 1, 2, 2, FLAW_OVER_INFO, 0);
      queue_frame(0, 0, 1, 2, FLAW_OVER_INFO, 1);

      while (byte_count < 300) queue_random_unit();
      queue_delims(8'h00, 8'hFF);
      while (byte_count < 550) queue_random_unit();

      push_cmd(CMD_IDLE, 8'h00, CSR_START_DELIM, 52, 6);
      queue_delims(8'hFF, 8'h00);
      while (byte_count < 850) queue_random_unit();
      // same value for both delimiters
      queue_delims(8'h7E, 8'h7E);
      while (byte_count < 1050) queue_random_unit();

      push_cmd(CMD_IDLE, 8'h00, CSR_START_DELIM, 0, 0);
      queue_delims($urandom_range(255), $urandom_range(255));
      // long receiver stall while frames keep coming
      push_cmd(CMD_HOLD, 8'h00, CSR_START_DELIM, 0, 0);
      while (byte_count < 1250) queue_random_unit();
      push_cmd(CMD_DRAIN, 8'h00, CSR_START_DELIM, 0, 0);
      while (byte_count < 1400) queue_random_unit();

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (stim_q.size() != 0 || req_valid || section_items.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("rpc_frame_deframer_tb passed");
      else
         $display("rpc_frame_deframer_tb failed");
      $finish;
   end

endmodule
